// ===== rtl/mcls_pkg.sv =====
// Shared types and constants for the motor command link sender.
// No dependencies; used by every module of the block.
package mcls_pkg;

   typedef enum logic [2:0] {
      FUNC_RELIABLE   = 3'd0,
      FUNC_UNRELIABLE = 3'd1,
      FUNC_TICK       = 3'd2,
      FUNC_SER_BYTE   = 3'd3,
      FUNC_CAN_FRAME  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      KIND_TX_BYTE = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_TIMEOUT = 2'd2,
      KIND_BUSY    = 2'd3
   } kind_type;

   localparam logic [1:0] REG_LINK_MODE = 2'd0;
   localparam logic [1:0] REG_CAN_ID    = 2'd1;
   localparam logic [1:0] REG_RESEND    = 2'd2;
   localparam logic [1:0] REG_MAX_WAIT  = 2'd3;

   localparam logic [7:0] SYNC_BYTE = 8'hA5;
   localparam logic [4:0] SER_LAST  = 5'd20;
   localparam logic [4:0] CAN_LAST  = 5'd7;

   typedef struct packed {
      logic [2:0]        func;
      logic [7:0]        motor_id;
      logic [3:0][31:0]  words;
      logic [7:0]        rx_byte;
      logic [10:0]       rx_frame_id;
   } item_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] tx_byte;
      logic [1:0] frame_number;
      logic       frame_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic        link_mode;
      logic [10:0] can_frame_id;
      logic [15:0] resend_interval;
      logic [15:0] max_wait;
   } cfg_type;

endpackage

// ===== rtl/motor_command_link_sender.sv =====
// Motor command link sender, a stop-and-wait sender for motor commands over a
// serial or CAN link. Requests enter a two-deep queue; the engine takes one
// request at a time and emits at most one result per clock into a four-deep
// result queue. A reliable serial send takes the request, emits the 21 bytes
// of its frame, checks the acknowledgement and flushes; an unreliable one
// skips the check. A reliable CAN send emits its first frame and then one
// frame for each acknowledgement that advances it; an unreliable CAN send
// emits three frames. The frame builder works one byte at a time; a full
// result queue stalls the engine until a result is popped. Registers at
// byte addresses 0 link_mode, 4 can_frame_id, 8 resend_interval, 12 max_wait.
// Depends on mcls_pkg, mcls_front, mcls_engine and mcls_out_queue.
module motor_command_link_sender #(
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_motor_id,
   input  logic [31:0] req_cmd_word0,
   input  logic [31:0] req_cmd_word1,
   input  logic [31:0] req_cmd_word2,
   input  logic [31:0] req_cmd_word3,
   input  logic [7:0]  req_rx_byte,
   input  logic [10:0] req_rx_frame_id,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [1:0]  rsp_frame_number,
   output logic        rsp_frame_end,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   mcls_pkg::cfg_type  cfg_ff;
   mcls_pkg::item_type push_item, item;
   mcls_pkg::rsp_type  out_data, rd_data;
   logic item_valid, take, out_wr, out_full;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{1'b0, 11'd0, 16'd10, 16'd100};
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            mcls_pkg::REG_LINK_MODE: cfg_ff.link_mode       <= pwdata[0];
            mcls_pkg::REG_CAN_ID:    cfg_ff.can_frame_id    <= pwdata[10:0];
            mcls_pkg::REG_RESEND:    cfg_ff.resend_interval <= pwdata[15:0];
            mcls_pkg::REG_MAX_WAIT:  cfg_ff.max_wait        <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         mcls_pkg::REG_LINK_MODE: prdata = {31'd0, cfg_ff.link_mode};
         mcls_pkg::REG_CAN_ID:    prdata = {21'd0, cfg_ff.can_frame_id};
         mcls_pkg::REG_RESEND:    prdata = {16'd0, cfg_ff.resend_interval};
         mcls_pkg::REG_MAX_WAIT:  prdata = {16'd0, cfg_ff.max_wait};
         default:                 prdata = 32'd0;
      endcase
   end

   assign push_item = '{req_func, req_motor_id,
                        {req_cmd_word3, req_cmd_word2, req_cmd_word1, req_cmd_word0},
                        req_rx_byte, req_rx_frame_id};

   mcls_front u_front (
      .clock, .reset, .push, .full, .push_item,
      .item_valid, .item, .take
   );

   mcls_engine #(.TIME_WIDTH(TIME_WIDTH)) u_engine (
      .clock, .reset, .cfg(cfg_ff), .item_valid, .item, .take,
      .out_wr, .out_data, .out_full
   );

   mcls_out_queue u_out (
      .clock, .reset, .wr(out_wr), .wr_data(out_data), .nearly_full(out_full),
      .empty, .rd_data, .pop
   );

   assign rsp_result_kind  = rd_data.result_kind;
   assign rsp_tx_byte      = rd_data.tx_byte;
   assign rsp_frame_number = rd_data.frame_number;
   assign rsp_frame_end    = rd_data.frame_end;
   assign rsp_last         = rd_data.last;

endmodule

// ===== rtl/mcls_front.sv =====
// Request queue of the link sender: takes requests and holds them for the engine.
// Depends on mcls_pkg.
module mcls_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  mcls_pkg::item_type push_item,
   output logic              item_valid,
   output mcls_pkg::item_type item,
   input  logic              take
);

   mcls_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       wr_en, rd_en;

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = mem_ff[rd_ptr_ff];
   assign wr_en      = push && !full;
   assign rd_en      = take && item_valid;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (wr_en) wr_ptr_ff <= !wr_ptr_ff;
         if (rd_en) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, wr_en} - {1'b0, rd_en};
      end
   end

endmodule

// ===== rtl/mcls_out_queue.sv =====
// Result queue of the link sender: parts the engine from the consumer.
// Depends on mcls_pkg.
module mcls_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  mcls_pkg::rsp_type wr_data,
   output logic             nearly_full,
   output logic             empty,
   output mcls_pkg::rsp_type rd_data,
   input  logic             pop
);

   mcls_pkg::rsp_type mem_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       rd_en;

   assign nearly_full = (count_ff == 3'd4);
   assign empty       = (count_ff == 3'd0);
   assign rd_data     = mem_ff[rd_ptr_ff];
   assign rd_en       = pop && !empty;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (wr)    wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + {2'd0, wr} - {2'd0, rd_en};
      end
   end

endmodule

// ===== rtl/mcls_engine.sv =====
// Send engine: runs the stop-and-wait protocol and builds frames byte by byte.
// Depends on mcls_pkg; fed by mcls_front, drains into mcls_out_queue.
module mcls_engine #(
   parameter int TIME_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  mcls_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  mcls_pkg::item_type item,
   output logic              take,
   output logic              out_wr,
   output mcls_pkg::rsp_type  out_data,
   input  logic              out_full
);

   localparam int CW   = TIME_WIDTH + 1;
   localparam int CMPW = (CW > 16) ? CW : 17;
   localparam logic [CW-1:0] CAP = {CW{1'b1}};

   typedef enum logic [1:0] {IDLE, SEND, ACK, FLUSH} state_type;

   state_type state_ff, state_in;
   logic [7:0]  seq_ff, seq_in;
   logic        busy_ff, busy_in;
   logic [1:0]  stage_ff, stage_in;
   logic [CW-1:0] start_ff, start_in, send_ff, send_in;
   logic [7:0]  hid_ff, hid_in;
   logic [3:0][31:0] hw_ff, hw_in;
   logic [7:0]  ser_ff, ser_in;
   logic [10:0] cid_ff, cid_in;
   logic [7:0]  cbyte_ff, cbyte_in;
   logic [4:0]  idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;
   logic [1:0]  fnum_ff, fnum_in;
   logic        can_ff, can_in;
   logic        multi_ff, multi_in;
   logic        rel_ff, rel_in;
   logic        pend_v_ff, pend_v_in;
   mcls_pkg::rsp_type pend_ff, pend_in;

   logic        can_emit, frame_last;
   logic [7:0]  cur_byte, ack_byte;
   logic [CW-1:0] start_nx, send_nx;

   function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] i);
      word_byte = w[{i, 3'b000} +: 8];
   endfunction

   always_comb begin
      logic [4:0] j;
      logic [31:0] body;
      j = idx_ff - 5'd4;
      body = (fnum_ff == 2'd1) ? hw_ff[0] : (fnum_ff == 2'd2) ? hw_ff[1] : hw_ff[2];
      cur_byte = 8'd0;
      if (!can_ff) begin
         if (idx_ff < 5'd2) cur_byte = mcls_pkg::SYNC_BYTE;
         else if (idx_ff == 5'd2) cur_byte = seq_ff;
         else if (idx_ff == 5'd3) cur_byte = hid_ff;
         else if (idx_ff == mcls_pkg::SER_LAST) cur_byte = sum_ff;
         else cur_byte = word_byte(hw_ff[j[3:2]], j[1:0]);
      end else begin
         case (idx_ff)
            5'd0: cur_byte = {fnum_ff, seq_ff[5:0]};
            5'd1: cur_byte = (fnum_ff == 2'd1) ? hid_ff :
                             (fnum_ff == 2'd2) ? hw_ff[3][7:0] : hw_ff[3][23:16];
            5'd2: cur_byte = (fnum_ff == 2'd1) ? 8'd0 :
                             (fnum_ff == 2'd2) ? hw_ff[3][15:8] : hw_ff[3][31:24];
            5'd7: cur_byte = sum_ff;
            default: cur_byte = word_byte(body, 2'(idx_ff - 5'd3));
         endcase
      end
   end

   assign frame_last = can_ff ? (idx_ff == mcls_pkg::CAN_LAST) : (idx_ff == mcls_pkg::SER_LAST);
   assign can_emit   = !pend_v_ff || !out_full;
   assign ack_byte   = {stage_ff, seq_ff[5:0]};
   assign start_nx   = (start_ff == CAP) ? CAP : start_ff + 1'b1;
   assign send_nx    = (send_ff == CAP) ? CAP : send_ff + 1'b1;

   always_comb begin
      state_in = state_ff;  seq_in = seq_ff;     busy_in = busy_ff;
      stage_in = stage_ff;  start_in = start_ff; send_in = send_ff;
      hid_in = hid_ff;      hw_in = hw_ff;       ser_in = ser_ff;
      cid_in = cid_ff;      cbyte_in = cbyte_ff; idx_in = idx_ff;
      sum_in = sum_ff;      fnum_in = fnum_ff;   can_in = can_ff;
      multi_in = multi_ff;  rel_in = rel_ff;
      pend_v_in = pend_v_ff; pend_in = pend_ff;
      take = 1'b0;
      out_wr = 1'b0;
      out_data = pend_ff;
      case (state_ff)
         IDLE: begin
            if (item_valid) begin
               take = 1'b1;
               case (item.func)
                  mcls_pkg::FUNC_RELIABLE, mcls_pkg::FUNC_UNRELIABLE: begin
                     if (busy_ff) begin
                        pend_v_in = 1'b1;
                        pend_in = '{mcls_pkg::KIND_BUSY, 8'd0, 2'd0, 1'b0, 1'b0};
                        state_in = FLUSH;
                     end else begin
                        hid_in = item.motor_id;
                        hw_in  = item.words;
                        rel_in = (item.func == mcls_pkg::FUNC_RELIABLE);
                        multi_in = (item.func == mcls_pkg::FUNC_UNRELIABLE) && cfg.link_mode;
                        can_in = cfg.link_mode;
                        fnum_in = cfg.link_mode ? 2'd1 : 2'd0;
                        seq_in = seq_ff + 8'd1;
                        idx_in = 5'd0;
                        sum_in = 8'd0;
                        state_in = SEND;
                        if (item.func == mcls_pkg::FUNC_RELIABLE) begin
                           busy_in = 1'b1;
                           stage_in = 2'd1;
                           start_in = '0;
                           send_in = '0;
                        end
                     end
                  end
                  mcls_pkg::FUNC_TICK: begin
                     if (busy_ff) begin
                        start_in = start_nx;
                        send_in = send_nx;
                        if (CMPW'(start_nx) > CMPW'(cfg.max_wait)) begin
                           busy_in = 1'b0;
                           pend_v_in = 1'b1;
                           pend_in = '{mcls_pkg::KIND_TIMEOUT, 8'd0, 2'd0, 1'b0, 1'b0};
                           state_in = FLUSH;
                        end else if (CMPW'(send_nx) > CMPW'(cfg.resend_interval)) begin
                           // resend the held command
                           rel_in = 1'b1;
                           multi_in = 1'b0;
                           can_in = cfg.link_mode;
                           fnum_in = cfg.link_mode ? stage_ff : 2'd0;
                           seq_in = seq_ff + 8'd1;
                           send_in = '0;
                           idx_in = 5'd0;
                           sum_in = 8'd0;
                           state_in = SEND;
                        end else begin
                           state_in = ACK;
                        end
                     end
                  end
                  mcls_pkg::FUNC_SER_BYTE: begin
                     ser_in = item.rx_byte;
                     state_in = ACK;
                  end
                  mcls_pkg::FUNC_CAN_FRAME: begin
                     cbyte_in = item.rx_byte;
                     cid_in = item.rx_frame_id;
                     state_in = ACK;
                  end
                  default: ;
               endcase
            end
         end
         SEND: begin
            if (can_emit) begin
               out_wr = pend_v_ff;
               pend_v_in = 1'b1;
               pend_in = '{mcls_pkg::KIND_TX_BYTE, cur_byte, fnum_ff, frame_last, 1'b0};
               sum_in = sum_ff + cur_byte;
               idx_in = idx_ff + 5'd1;
               if (frame_last) begin
                  idx_in = 5'd0;
                  sum_in = 8'd0;
                  if (multi_ff && fnum_ff != 2'd3) begin
                     fnum_in = fnum_ff + 2'd1;
                  end else begin
                     state_in = rel_ff ? ACK : FLUSH;
                  end
               end else if (!can_ff && idx_ff < 5'd2) begin
                  sum_in = 8'd0;
               end
            end
         end
         ACK: begin
            if (!busy_ff) begin
               state_in = FLUSH;
            end else if (!cfg.link_mode) begin
               if (ser_ff != seq_ff) begin
                  state_in = FLUSH;
               end else if (can_emit) begin
                  out_wr = pend_v_ff;
                  busy_in = 1'b0;
                  pend_v_in = 1'b1;
                  pend_in = '{mcls_pkg::KIND_DONE, 8'd0, 2'd0, 1'b0, 1'b0};
                  state_in = FLUSH;
               end
            end else if (cid_ff != cfg.can_frame_id || cbyte_ff != ack_byte) begin
               state_in = FLUSH;
            end else if (stage_ff == 2'd3) begin
               if (can_emit) begin
                  out_wr = pend_v_ff;
                  busy_in = 1'b0;
                  pend_v_in = 1'b1;
                  pend_in = '{mcls_pkg::KIND_DONE, 8'd0, 2'd0, 1'b0, 1'b0};
                  state_in = FLUSH;
               end
            end else begin
               // advance to the next CAN frame and send it
               stage_in = stage_ff + 2'd1;
               start_in = '0;
               send_in = '0;
               rel_in = 1'b1;
               multi_in = 1'b0;
               can_in = 1'b1;
               fnum_in = stage_ff + 2'd1;
               seq_in = seq_ff + 8'd1;
               idx_in = 5'd0;
               sum_in = 8'd0;
               state_in = SEND;
            end
         end
         FLUSH: begin
            if (!pend_v_ff) begin
               state_in = IDLE;
            end else if (!out_full) begin
               out_wr = 1'b1;
               out_data.last = 1'b1;
               pend_v_in = 1'b0;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      hid_ff   <= hid_in;
      hw_ff    <= hw_in;
      idx_ff   <= idx_in;
      sum_ff   <= sum_in;
      fnum_ff  <= fnum_in;
      can_ff   <= can_in;
      multi_ff <= multi_in;
      rel_ff   <= rel_in;
      pend_ff  <= pend_in;
      if (reset) begin
         state_ff  <= IDLE;
         seq_ff    <= 8'd0;
         busy_ff   <= 1'b0;
         stage_ff  <= 2'd0;
         start_ff  <= '0;
         send_ff   <= '0;
         ser_ff    <= 8'd0;
         cid_ff    <= 11'd0;
         cbyte_ff  <= 8'd0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seq_ff    <= seq_in;
         busy_ff   <= busy_in;
         stage_ff  <= stage_in;
         start_ff  <= start_in;
         send_ff   <= send_in;
         ser_ff    <= ser_in;
         cid_ff    <= cid_in;
         cbyte_ff  <= cbyte_in;
         pend_v_ff <= pend_v_in;
      end
   end

endmodule
